### design/ppg_pkg.sv
package ppg_pkg;

	// Default parameter values
	localparam int COORD_BITS_DEFAULT    = 12;
	localparam int PALETTE_STEPS_DEFAULT = 64;

	// Fixed field widths
	localparam int FRAME_BITS     = 8;
	localparam int OFFSET_BITS    = 24;
	localparam int ARGB_BITS      = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PALETTE_DEPTH  = 256;
	localparam int SINE_DEPTH     = 256;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Register reset values
	localparam int FRAME_RESET    = 0;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int CENTER_X_RESET = 320;
	localparam int CENTER_Y_RESET = 240;

	// Frames per pattern
	localparam int FRAMES_PER_MODE = 60;

	// Palette index scale: floor(126 * s / 255), s = 2*t or ta + tb
	localparam int PAL_SCALE = 126;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME    = 3'd0,
		REG_WIDTH    = 3'd1,
		REG_HEIGHT   = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_SQUARE,
		MODE_MIXED,
		MODE_BLACK
	} mode_t;

	typedef logic [7:0] sine_rom_t [SINE_DEPTH];

	// pi in Q61
	localparam logic [63:0] PI_Q61  = 64'h6487ED5110B4611A;
	localparam logic [63:0] STEP_Q61 = PI_Q61 / 64'd255;

	// Key colours, RGB: red, green, blue, cyan
	function automatic logic [23:0] key_rgb(input int j);
		logic [23:0] rgb;
		case (j & 3)
			0:       rgb = 24'hFF0000;
			1:       rgb = 24'h00FF00;
			2:       rgb = 24'h0000FF;
			default: rgb = 24'h00FFFF;
		endcase
		return rgb;
	endfunction

	// Numerator of one palette channel: a*den + (b - a)*i
	function automatic int pal_num(input int j, input int i, input int den, input int ch);
		logic [23:0] ca;
		logic [23:0] cb;
		int a;
		int b;
		ca = key_rgb(j);
		cb = key_rgb(j + 1);
		a  = int'(ca[23 - 8*ch -: 8]);
		b  = int'(cb[23 - 8*ch -: 8]);
		return a * den + (b - a) * i;
	endfunction

	// (a*b) >> 61, low 64 bits
	function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[124:61];
	endfunction

	// floor(num / den), shift-and-subtract; only used while building tables
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		q = 64'd0;
		r = 65'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r    = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sin(pi*n/255) in Q61, Taylor series, n in 0..127
	function automatic logic [63:0] sin_q61(input int n);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] dv;
		x    = STEP_Q61 * 64'(n);
		x2   = mul_q61(x, x);
		term = x;
		sum  = x;
		for (int k = 1; k < 24; k++) begin
			if (term != 64'd0) begin
				dv   = 64'((2 * k) * (2 * k + 1));
				term = div_u64(mul_q61(term, x2), dv);
				if ((k & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	// entry i = ceil(127.5 * (1 + sin(2*pi*i/255))), exact integer form
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		int m;
		int n;
		logic neg;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] r;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			m   = 2 * i;
			neg = 1'b0;
			if (m > 255) begin
				neg = 1'b1;
				m   = m - 255;
			end
			n = (m <= 127) ? m : 255 - m;
			t = (sin_q61(n) >> 9) * 64'd255;
			u = neg ? ((64'd255 << 52) - t) : ((64'd255 << 52) + t);
			r = (u + (64'd1 << 53) - 64'd1) >> 53;
			rom[i] = r[7:0];
		end
		return rom;
	endfunction

endpackage

### design/ppg_cfg.sv
module ppg_cfg #(
	parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	output logic [ppg_pkg::FRAME_BITS-1:0]      frame,
	output logic [COORD_BITS-1:0]               width,
	output logic [COORD_BITS-1:0]               height,
	output logic [COORD_BITS-1:0]               center_x,
	output logic [COORD_BITS-1:0]               center_y
);

	logic [ppg_pkg::FRAME_BITS-1:0] frame_q;
	logic [COORD_BITS-1:0]          width_q;
	logic [COORD_BITS-1:0]          height_q;
	logic [COORD_BITS-1:0]          center_x_q;
	logic [COORD_BITS-1:0]          center_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q    <= ppg_pkg::FRAME_BITS'(ppg_pkg::FRAME_RESET);
			width_q    <= COORD_BITS'(ppg_pkg::WIDTH_RESET);
			height_q   <= COORD_BITS'(ppg_pkg::HEIGHT_RESET);
			center_x_q <= COORD_BITS'(ppg_pkg::CENTER_X_RESET);
			center_y_q <= COORD_BITS'(ppg_pkg::CENTER_Y_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (ppg_pkg::cfg_reg_t'(cfg_index))
				ppg_pkg::REG_FRAME:    frame_q    <= cfg_data[ppg_pkg::FRAME_BITS-1:0];
				ppg_pkg::REG_WIDTH:    width_q    <= cfg_data;
				ppg_pkg::REG_HEIGHT:   height_q   <= cfg_data;
				ppg_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				ppg_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign frame    = frame_q;
	assign width    = width_q;
	assign height   = height_q;
	assign center_x = center_x_q;
	assign center_y = center_y_q;

endmodule

### design/ppg_color.sv
module ppg_color #(
	parameter int COORD_BITS    = ppg_pkg::COORD_BITS_DEFAULT,
	parameter int PALETTE_STEPS = ppg_pkg::PALETTE_STEPS_DEFAULT
) (
	input  logic [COORD_BITS-1:0]             pixel_x,
	input  logic [COORD_BITS-1:0]             pixel_y,
	input  logic [ppg_pkg::FRAME_BITS-1:0]    frame,
	input  logic [COORD_BITS-1:0]             center_x,
	input  logic [COORD_BITS-1:0]             center_y,
	output logic [ppg_pkg::ARGB_BITS-1:0]     pixel_argb
);

	// distance width, doubled width, reciprocal shift for /5
	localparam int DW = COORD_BITS + 1;
	localparam int MB = DW + 1;
	localparam int S  = MB + 2;
	localparam int PW = MB + S;
	localparam int DIV5_MUL = (2**S + 4) / 5;

	localparam ppg_pkg::sine_rom_t SINE_ROM = ppg_pkg::build_sine_rom();

	logic [23:0] palette [ppg_pkg::PALETTE_DEPTH];

	for (genvar k = 0; k < ppg_pkg::PALETTE_DEPTH; k++) begin : g_pal
		localparam int J   = k / PALETTE_STEPS;
		localparam int I   = k % PALETTE_STEPS;
		localparam int DEN = PALETTE_STEPS - 1;
		localparam int NR  = ppg_pkg::pal_num(J, I, DEN, 0);
		localparam int NG  = ppg_pkg::pal_num(J, I, DEN, 1);
		localparam int NB  = ppg_pkg::pal_num(J, I, DEN, 2);
		localparam int VR  = (NR > 0) ? NR / DEN : 0;
		localparam int VG  = (NG > 0) ? NG / DEN : 0;
		localparam int VB  = (NB > 0) ? NB / DEN : 0;
		assign palette[k] = (J >= 4) ? 24'd0 : {8'(VR), 8'(VG), 8'(VB)};
	end

	// (floor(2d/5) + phase) mod 256
	function automatic logic [7:0] sine_idx(input logic [DW-1:0] d, input logic [7:0] ph);
		logic [MB-1:0] m;
		logic [PW-1:0] p;
		m = {d, 1'b0};
		p = PW'(m) * PW'(DIV5_MUL);
		return p[S +: 8] + ph;
	endfunction

	ppg_pkg::mode_t mode;
	logic [7:0]            phase;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [COORD_BITS-1:0] cheb;
	logic [DW-1:0]         manh;
	logic [DW-1:0]         dist_a;
	logic [7:0]            t_a;
	logic [7:0]            t_b;
	logic [8:0]            t_sum;
	logic [15:0]           scaled;
	logic [15:0]           div_sum;
	logic [7:0]            pal_idx;

	always_comb begin
		if (frame < 8'(ppg_pkg::FRAMES_PER_MODE)) begin
			mode = ppg_pkg::MODE_PLAIN;
		end else if (frame < 8'(2 * ppg_pkg::FRAMES_PER_MODE)) begin
			mode = ppg_pkg::MODE_SQUARE;
		end else if (frame < 8'(3 * ppg_pkg::FRAMES_PER_MODE)) begin
			mode = ppg_pkg::MODE_MIXED;
		end else begin
			mode = ppg_pkg::MODE_BLACK;
		end
	end

	assign phase = {frame[6:0], 1'b0};
	assign dx    = (pixel_x > center_x) ? pixel_x - center_x : center_x - pixel_x;
	assign dy    = (pixel_y > center_y) ? pixel_y - center_y : center_y - pixel_y;
	assign cheb  = (dx > dy) ? dx : dy;
	assign manh  = DW'(dx) + DW'(dy);

	always_comb begin
		case (mode)
			ppg_pkg::MODE_PLAIN: dist_a = DW'(pixel_y);
			ppg_pkg::MODE_MIXED: dist_a = manh;
			default:             dist_a = DW'(cheb);
		endcase
	end

	assign t_a = SINE_ROM[sine_idx(dist_a, phase)];
	assign t_b = SINE_ROM[sine_idx(DW'(cheb), phase)];

	// single lookup: 252*t = 126*(2t); mixed: 126*(ta+tb)
	assign t_sum  = (mode == ppg_pkg::MODE_MIXED) ? 9'(t_a) + 9'(t_b) : {t_a, 1'b0};
	assign scaled = 16'(t_sum) * 16'(ppg_pkg::PAL_SCALE);

	// floor(n/255) = (n + 1 + (n >> 8)) >> 8, exact below 255*255
	assign div_sum = scaled + 16'd1 + 16'(scaled[15:8]);
	assign pal_idx = div_sum[15:8];

	assign pixel_argb = (mode == ppg_pkg::MODE_BLACK) ?
		{ppg_pkg::ALPHA_OPAQUE, 24'd0} : {ppg_pkg::ALPHA_OPAQUE, palette[pal_idx]};

endmodule

### design/ppg_addr.sv
module ppg_addr #(
	parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
	input  logic [COORD_BITS-1:0]              pixel_x,
	input  logic [COORD_BITS-1:0]              pixel_y,
	input  logic [COORD_BITS-1:0]              width,
	input  logic [COORD_BITS-1:0]              height,
	output logic [ppg_pkg::OFFSET_BITS-1:0]    pixel_offset,
	output logic                               in_bounds
);

	localparam int SW = (2 * COORD_BITS + 1 > ppg_pkg::OFFSET_BITS) ?
		2 * COORD_BITS + 1 : ppg_pkg::OFFSET_BITS;

	logic [SW-1:0] lin;

	assign lin          = SW'(pixel_y) * SW'(width) + SW'(pixel_x);
	assign pixel_offset = lin[ppg_pkg::OFFSET_BITS-1:0];
	assign in_bounds    = (pixel_x < width) && (pixel_y < height);

endmodule

### design/plasma_pixel_generator.sv
// Plasma pixel generator: colours one pixel coordinate per transfer.
//
// Input channel (in_valid / in_stall / pixel_x / pixel_y): one coordinate per
// transfer. Output channel (out_valid / out_stall / pixel_argb / pixel_offset /
// in_bounds): one result per accepted coordinate, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
// writes, always ready; write only while no pixel is in flight. Indexes:
// frame, width, height, center_x, center_y; others are dropped.
//
// A pixel goes through the input register and then the result register to
// out_valid. Throughput is one pixel per cycle while out_stall is low; each
// register holds one pixel, and all colour, offset and bound math is between.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more pixel; in_stall rises only when both are full.
// Reset (arst_n low, asynchronous) empties both registers and loads the
// config defaults: frame 0, 640 x 480, centre (320, 240). The sine and
// palette tables are constants and need no fill after reset.
module plasma_pixel_generator #(
	parameter int COORD_BITS    = ppg_pkg::COORD_BITS_DEFAULT,
	parameter int PALETTE_STEPS = ppg_pkg::PALETTE_STEPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [COORD_BITS-1:0]               pixel_x,
	input  logic [COORD_BITS-1:0]               pixel_y,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ppg_pkg::ARGB_BITS-1:0]       pixel_argb,
	output logic [ppg_pkg::OFFSET_BITS-1:0]     pixel_offset,
	output logic                                in_bounds,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data
);

	// configuration
	logic [ppg_pkg::FRAME_BITS-1:0] frame;
	logic [COORD_BITS-1:0]          width;
	logic [COORD_BITS-1:0]          height;
	logic [COORD_BITS-1:0]          center_x;
	logic [COORD_BITS-1:0]          center_y;

	// input register
	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;

	// result register
	logic                              valid_s2;
	logic [ppg_pkg::ARGB_BITS-1:0]     argb_s2;
	logic [ppg_pkg::OFFSET_BITS-1:0]   offset_s2;
	logic                              bounds_s2;

	// combinational results of the input register
	logic [ppg_pkg::ARGB_BITS-1:0]     argb_c;
	logic [ppg_pkg::OFFSET_BITS-1:0]   offset_c;
	logic                              bounds_c;

	logic s2_load;
	logic s1_load;

	ppg_cfg #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.frame    (frame),
		.width    (width),
		.height   (height),
		.center_x (center_x),
		.center_y (center_y)
	);

	ppg_color #(
		.COORD_BITS   (COORD_BITS),
		.PALETTE_STEPS(PALETTE_STEPS)
	) u_color (
		.pixel_x   (x_s1),
		.pixel_y   (y_s1),
		.frame     (frame),
		.center_x  (center_x),
		.center_y  (center_y),
		.pixel_argb(argb_c)
	);

	ppg_addr #(
		.COORD_BITS(COORD_BITS)
	) u_addr (
		.pixel_x     (x_s1),
		.pixel_y     (y_s1),
		.width       (width),
		.height      (height),
		.pixel_offset(offset_c),
		.in_bounds   (bounds_c)
	);

	// result register takes a new word when empty or when its word leaves now
	assign s2_load  = !valid_s2 || !out_stall;
	// input register stalls only while it is full and cannot move on
	assign in_stall = valid_s1 && !s2_load;
	assign s1_load  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			argb_s2   <= argb_c;
			offset_s2 <= offset_c;
			bounds_s2 <= bounds_c;
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_argb   = argb_s2;
	assign pixel_offset = offset_s2;
	assign in_bounds    = bounds_s2;

endmodule

### design/ppg_checker.sv
module ppg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [ppg_pkg::ARGB_BITS-1:0]     pixel_argb,
	input logic [ppg_pkg::OFFSET_BITS-1:0]   pixel_offset,
	input logic                              in_bounds
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_argb) && $stable(pixel_offset)
			&& $stable(in_bounds))
		else $error("stalled result changed");

	// input side stalls only when both registers are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// a transfer with a free output path reaches out_valid through both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after transfer");

	// every colour word is opaque
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_argb[31:24] == ppg_pkg::ALPHA_OPAQUE)
		else $error("alpha byte not opaque");

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_argb  (pixel_argb),
	.pixel_offset(pixel_offset),
	.in_bounds   (in_bounds)
);
